// ===== hdl/lbab_pkg.sv =====
// Package: shared types, register map and constants of the light-barrier alarm blinker.
`timescale 1ns / 1ps
`default_nettype none
package lbab_pkg;

  localparam int unsigned CfgW   = 16;
  localparam int unsigned CntW   = 17;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;

  localparam logic [CntW-1:0] CountCap = 17'd65536;

  localparam logic [CfgW-1:0] LampPeriodRst = 16'd500;
  localparam logic [CfgW-1:0] IdleLimitRst  = 16'd30000;
  localparam logic [CfgW-1:0] HoldoffRst    = 16'd500;

  // Register index, taken from paddr[3:2].
  typedef enum logic [1:0] {
    RegLampPeriod = 2'd0,
    RegIdleLimit  = 2'd1,
    RegHoldoff    = 2'd2,
    RegUnused     = 2'd3
  } lbab_reg_e;

  typedef struct packed {
    logic [CfgW-1:0] lamp_period;
    logic [CfgW-1:0] idle_limit;
    logic [CfgW-1:0] holdoff;
  } lbab_cfg_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    sat_inc = (v >= CountCap) ? CountCap : v + 1'b1;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/lbab_tick_if.sv =====
// Interface: input channel carrying one millisecond tick word with both barrier levels.
`timescale 1ns / 1ps
`default_nettype none
interface lbab_tick_if;
  logic valid;
  logic ready;
  logic barrier_one;
  logic barrier_two;

  modport source (output valid, output barrier_one, output barrier_two, input ready);
  modport sink   (input valid, input barrier_one, input barrier_two, output ready);
endinterface
`default_nettype wire

// ===== hdl/lbab_lamp_if.sv =====
// Interface: output channel carrying one lamp and alarm word per tick.
`timescale 1ns / 1ps
`default_nettype none
interface lbab_lamp_if;
  logic valid;
  logic ready;
  logic lamp_a;
  logic lamp_b;
  logic alarm_on;

  modport source (output valid, output lamp_a, output lamp_b, output alarm_on, input ready);
  modport sink   (input valid, input lamp_a, input lamp_b, input alarm_on, output ready);
endinterface
`default_nettype wire

// ===== hdl/lbab_cfg_regs.sv =====
// Module: APB-style configuration registers of the alarm blinker.
`timescale 1ns / 1ps
`default_nettype none
module lbab_cfg_regs import lbab_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready,
  output lbab_cfg_t             cfg_o
);

  lbab_cfg_t cfg_q, cfg_d;
  lbab_reg_e reg_sel;
  logic      wr_en;

  assign pready  = 1'b1;
  assign reg_sel = lbab_reg_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        RegLampPeriod: cfg_d.lamp_period = pwdata[CfgW-1:0];
        RegIdleLimit:  cfg_d.idle_limit  = pwdata[CfgW-1:0];
        RegHoldoff:    cfg_d.holdoff     = pwdata[CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegLampPeriod: prdata = {{(DataW-CfgW){1'b0}}, cfg_q.lamp_period};
      RegIdleLimit:  prdata = {{(DataW-CfgW){1'b0}}, cfg_q.idle_limit};
      RegHoldoff:    prdata = {{(DataW-CfgW){1'b0}}, cfg_q.holdoff};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lamp_period <= LampPeriodRst;
      cfg_q.idle_limit  <= IdleLimitRst;
      cfg_q.holdoff     <= HoldoffRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ===== hdl/lbab_core.sv =====
// Module: tick input register, lamp and alarm update, and result register.
`timescale 1ns / 1ps
`default_nettype none
module lbab_core import lbab_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire lbab_cfg_t cfg_i,
  lbab_tick_if.sink      tick_i,
  lbab_lamp_if.source    lamp_o
);

  logic            in_valid_q, in_valid_d;
  logic            in_b1_q, in_b2_q;
  logic            out_valid_q, out_valid_d;
  logic            out_free, adv, in_take;

  logic            alarm_q, alarm_d;
  logic            phase_q, phase_d;
  logic            lamp_a_q, lamp_a_d;
  logic            lamp_b_q, lamp_b_d;
  logic [CntW-1:0] blink_q, blink_d;
  logic [CntW-1:0] since_q, since_d;

  logic [CntW-1:0] blink_inc, since_inc;
  logic            hit, blink_over;

  // The result register is free when empty or when its word leaves this cycle.
  assign out_free     = !out_valid_q || lamp_o.ready;
  assign adv          = in_valid_q && out_free;
  assign tick_i.ready = !in_valid_q || out_free;
  assign in_take      = tick_i.valid && tick_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (tick_i.ready) begin
      in_valid_d = tick_i.valid;
    end
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = in_valid_q;
    end
  end

  assign hit        = !in_b1_q || !in_b2_q;
  assign blink_inc  = sat_inc(blink_q);
  assign since_inc  = sat_inc(since_q);
  assign blink_over = blink_inc > {1'b0, cfg_i.lamp_period};

  always_comb begin
    alarm_d  = alarm_q;
    phase_d  = phase_q;
    lamp_a_d = lamp_a_q;
    lamp_b_d = lamp_b_q;
    blink_d  = blink_q;
    since_d  = since_q;
    if (adv) begin
      blink_d = blink_inc;
      since_d = since_inc;
      // Lamps follow the phase that held before any flip on this tick.
      if (alarm_q) begin
        lamp_a_d = !phase_q;
        lamp_b_d = phase_q;
        if (blink_over) begin
          blink_d = '0;
          phase_d = !phase_q;
        end
      end else if (blink_over) begin
        lamp_a_d = 1'b0;
        lamp_b_d = 1'b0;
      end
      if (hit) begin
        since_d = '0;
        if (since_inc >= {1'b0, cfg_i.holdoff}) begin
          alarm_d = !alarm_q;
        end
      end
      if (since_d > {1'b0, cfg_i.idle_limit}) begin
        alarm_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      alarm_q     <= 1'b0;
      phase_q     <= 1'b0;
      lamp_a_q    <= 1'b0;
      lamp_b_q    <= 1'b0;
      blink_q     <= '0;
      since_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      alarm_q     <= alarm_d;
      phase_q     <= phase_d;
      lamp_a_q    <= lamp_a_d;
      lamp_b_q    <= lamp_b_d;
      blink_q     <= blink_d;
      since_q     <= since_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_b1_q <= tick_i.barrier_one;
      in_b2_q <= tick_i.barrier_two;
    end
  end

  // The lamp state only changes when a word moves into the result register,
  // so it doubles as the result payload.
  assign lamp_o.valid    = out_valid_q;
  assign lamp_o.lamp_a   = lamp_a_q;
  assign lamp_o.lamp_b   = lamp_b_q;
  assign lamp_o.alarm_on = alarm_q;

  a_lamps_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(lamp_a_q && lamp_b_q))
    else $error("both lamps lit at once");

  a_counters_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (blink_q <= CountCap) && (since_q <= CountCap))
    else $error("elapsed counter beyond its cap");

  a_hit_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && hit) |=> (since_q == '0))
    else $error("interruption did not restart the pause count");

  a_no_update_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ($stable(alarm_q) && $stable(phase_q) && $stable(blink_q)))
    else $error("state changed without a word advancing");

endmodule
`default_nettype wire

// ===== hdl/light_barrier_alarm_blinker.sv =====
// Path: an accepted tick word goes from the input register to the result register.
// Throughput: one tick word per clock cycle, set by the single-pass update between
// the input register and the result register; a stalled result holds both stages.
// Reset: rst_ni clears both stages, the alarm, phase, lamps and elapsed counters, and
// loads the interval 500, timeout 30000 and pause 500 into the configuration registers.
`timescale 1ns / 1ps
`default_nettype none
module light_barrier_alarm_blinker import lbab_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready,
  lbab_tick_if.sink             tick_i,
  lbab_lamp_if.source           lamp_o
);

  lbab_cfg_t cfg;

  lbab_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lbab_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .tick_i (tick_i),
    .lamp_o (lamp_o)
  );

endmodule
`default_nettype wire
